>>> hw/rtl/aes_pkg.sv
// AES-128 package: payload structs, S-box function, round helpers.
// Used by every module of the cipher core; depends on nothing.
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam logic [7:0]  RconInit  = 8'h01;

  typedef enum logic [0:0] {
    CfgKeyHigh = 1'b0,
    CfgKeyLow  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } out_item_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    unique case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [31:0] mix_column(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
    a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
    d0 = xtime(a0); d1 = xtime(a1); d2 = xtime(a2); d3 = xtime(a3);
    return {d0 ^ d1 ^ a1 ^ a2 ^ a3, a0 ^ d1 ^ d2 ^ a2 ^ a3,
            a0 ^ a1 ^ d2 ^ d3 ^ a3, d0 ^ a0 ^ a1 ^ a2 ^ d3};
  endfunction

  // ShiftRows after SubBytes on the whole state; word 0 in bits 127:96.
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [31:0] w [4];
    logic [31:0] t [4];
    for (int i = 0; i < 4; i++) begin
      w[i] = sub_word(s[127-32*i -: 32]);
    end
    for (int i = 0; i < 4; i++) begin
      t[i] = {w[i][31:24], w[(i+1)%4][23:16], w[(i+2)%4][15:8], w[(i+3)%4][7:0]};
    end
    return {t[0], t[1], t[2], t[3]};
  endfunction

  function automatic logic [127:0] mix_state(input logic [127:0] s);
    return {mix_column(s[127:96]), mix_column(s[95:64]),
            mix_column(s[63:32]), mix_column(s[31:0])};
  endfunction

  // One key expansion step: next four round-key words from previous four.
  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    t  = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h0};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

>>> hw/rtl/aes_key_sched.sv
// AES-128 key schedule: round keys expanded stage by stage beside the data.
// Depends on aes_pkg. Each stage's key register moves with its state register.
module aes_key_sched (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [127:0]         key_i,
  output logic [127:0]         rk_o [11]
);
  // k_q[i] holds round key i of the transaction sitting in stage i; round i+1
  // derives its key from it in the same cycle, so a key write applies to the
  // next transaction accepted.
  logic [127:0] k_q [10];
  logic [127:0] k_d [11];
  logic [7:0]   rc [10];

  always_comb begin
    rc[0] = aes_pkg::RconInit;
    for (int i = 1; i < 10; i++) begin
      rc[i] = aes_pkg::xtime(rc[i-1]);
    end
  end

  always_comb begin
    k_d[0] = key_i;
    for (int i = 1; i < 11; i++) begin
      k_d[i] = aes_pkg::next_key(k_q[i-1], rc[i-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 10; i++) begin
        k_q[i] <= k_d[i];
      end
    end
  end

  assign rk_o = k_d;
endmodule

>>> hw/rtl/aes_round.sv
// One AES round stage with its valid bit and stall-aware register.
// Depends on aes_pkg.
module aes_round #(
  parameter bit Final = 1'b0
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  logic [127:0] state_i,
  input  logic [127:0] rk_i,
  output logic         valid_o,
  output logic [127:0] state_o
);
  logic [127:0] ss, state_d, state_q;
  logic         valid_q;

  always_comb begin
    ss = aes_pkg::sub_shift(state_i);
    state_d = (Final ? ss : aes_pkg::mix_state(ss)) ^ rk_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
endmodule

>>> hw/rtl/aes128_block_encrypt_core.sv
// AES-128 encryption core top level: key registers, input AddRoundKey
// stage and ten round stages. Depends on aes_pkg, aes_key_sched, aes_round.
//
//  channel | signals                  | direction
//  --------+--------------------------+----------
//  in      | in_valid_i/in_stall_o    | sink, in_item_t
//  out     | out_valid_o/out_stall_i  | source, out_item_t
//  cfg     | cfg_we_i/idx/data        | write only, key_high / key_low
//
// One transaction per cycle unless the output stalls. Stages: AddRoundKey
// plus one register per round. Reset clears valid bits and keys.
// The pipeline advances as a whole when the last stage is empty or taken;
// an output stall freezes every stage, and in_stall_o follows it.
// Round keys travel with each transaction, so a key write applies to the
// very next transaction accepted.
module aes128_block_encrypt_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  aes_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output aes_pkg::out_item_t  out_data_o,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [63:0]         cfg_data_i
);
  logic [63:0]  key_hi_q, key_lo_q;
  logic [127:0] rk [11];
  logic         en;
  logic         v [11];
  logic [127:0] s [11];
  logic         v0_q;
  logic [127:0] s0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_we_i) begin
      unique case (aes_pkg::cfg_idx_e'(cfg_idx_i))
        aes_pkg::CfgKeyHigh: key_hi_q <= cfg_data_i;
        aes_pkg::CfgKeyLow:  key_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  aes_key_sched u_ks (
    .clk_i (clk_i),
    .en_i  (en),
    .key_i ({key_hi_q, key_lo_q}),
    .rk_o  (rk)
  );

  // whole pipe moves unless the final result is held by the sink
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= {in_data_i.plain_high, in_data_i.plain_low} ^ rk[0];
    end
  end

  assign v[0] = v0_q;
  assign s[0] = s0_q;

  for (genvar r = 1; r <= 10; r++) begin : g_round
    aes_round #(.Final(r == 10)) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v[r-1]),
      .state_i (s[r-1]),
      .rk_i    (rk[r]),
      .valid_o (v[r]),
      .state_o (s[r])
    );
  end

  assign out_valid_o            = v[10];
  assign out_data_o.cipher_high = s[10][127:64];
  assign out_data_o.cipher_low  = s[10][63:0];
endmodule
